/* design/ssw_pkg.sv */
// shared types, constants and the segment table for the two-wire display writer
// no dependencies; imported by ssw_out_stage, the top level and the testbench
`default_nettype none

package ssw_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int PTR_W       = $clog2(FRAME_BYTES);
    localparam int LEN_W       = $clog2(FRAME_BYTES + 1);

    localparam logic [7:0] SEG_POINT   = 8'h80;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [2:0] MAX_CHARS   = 3'd5;
    localparam logic [2:0] COLON_INDEX = 3'd2;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_RAW    = 2'd1,
        OP_CHAR   = 2'd2,
        OP_START  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_BITS  = 3'd2,
        PH_ACK   = 3'd3,
        PH_STOP  = 3'd4
    } t_phase;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic dio_release;
        logic busy_res;
        logic frame_done;
        logic ack_error;
        logic overflow;
    } t_result;

    // seven-segment code of a decimal digit
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3f;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h4f;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6d;
            4'd6:    code = 8'h7d;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7f;
            4'd9:    code = 8'h6f;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* design/ssw_if.sv */
// valid/ready channel interfaces for the display writer input and result streams
// no dependencies
`default_nettype none

interface ssw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] value;
    logic       dio_in;

    modport source (output valid, output operation, output value, output dio_in, input ready);
    modport sink   (input valid, input operation, input value, input dio_in, output ready);
endinterface

interface ssw_out_if;
    logic valid;
    logic ready;
    logic clk_level;
    logic dio_level;
    logic dio_release;
    logic busy_res;
    logic frame_done;
    logic ack_error;
    logic overflow;

    modport source (output valid, output clk_level, output dio_level, output dio_release,
                    output busy_res, output frame_done, output ack_error, output overflow,
                    input ready);
    modport sink   (input valid, input clk_level, input dio_level, input dio_release,
                    input busy_res, input frame_done, input ack_error, input overflow,
                    output ready);
endinterface

`default_nettype wire

/* design/ssw_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module ssw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* design/ssw_out_stage.sv */
// two-entry result buffer: main register plus skid register
// depends on ssw_pkg and ssw_if
`default_nettype none

module ssw_out_stage
    import ssw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_can_push,
    ssw_out_if.source    o_out
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop        = r_main_valid && o_out.ready;
    assign o_can_push = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_out.valid       = r_main_valid;
    assign o_out.clk_level   = r_main.clk_level;
    assign o_out.dio_level   = r_main.dio_level;
    assign o_out.dio_release = r_main.dio_release;
    assign o_out.busy_res    = r_main.busy_res;
    assign o_out.frame_done  = r_main.frame_done;
    assign o_out.ack_error   = r_main.ack_error;
    assign o_out.overflow    = r_main.overflow;

endmodule

`default_nettype wire

/* design/seven_segment_two_wire_writer.sv */
// top level of the two-wire display writer: frame buffer, bus sequencer, result buffer
// depends on ssw_pkg, ssw_if, ssw_ram and ssw_out_stage
//
//  channel  | dir | payload                                            | accepted when
//  ---------+-----+----------------------------------------------------+---------------
//  i_in     | in  | operation, value, dio_in                           | valid & ready
//  o_out    | out | clk_level, dio_level, dio_release, busy_res,       | valid & ready
//           |     | frame_done, ack_error, overflow                    |
//
// one transaction is taken every cycle while i_in.ready is high; each gives one registered result
// the frame buffer ram is read ahead: its read address follows the next
// state, so the byte a transaction needs is already on the read port when it arrives
// a write to the entry being read is forwarded through a bypass register
// i_in.ready drops only while both result registers are full (o_out stalled)
// synchronous active-low reset; the frame buffer has no reset and no clearing pass
`default_nettype none

module seven_segment_two_wire_writer
    import ssw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssw_in_if.sink    i_in,
    ssw_out_if.source o_out
);

    // bus sequencer state
    t_phase           r_phase,    n_phase;
    logic             r_half,     n_half;
    logic [2:0]       r_bit_cnt,  n_bit_cnt;
    logic [LEN_W-1:0] r_byte_ptr, n_byte_ptr;
    logic [7:0]       r_shift,    n_shift;
    logic             r_nack,     n_nack;

    // frame buffer bookkeeping
    logic [LEN_W-1:0] r_frame_len, n_frame_len;
    logic [2:0]       r_char_idx,  n_char_idx;

    // ram port and read-during-write bypass
    logic             ram_wr_en;
    logic [PTR_W-1:0] ram_wr_addr;
    logic [7:0]       ram_wr_data;
    logic [PTR_W-1:0] ram_rd_addr;
    logic [7:0]       ram_rd_data;
    logic             r_byp_valid, n_byp_valid;
    logic [7:0]       r_byp_data;
    logic [7:0]       rd_byte;

    // transaction handshake and decoded fields
    logic             accept;
    logic             can_push;
    t_op              op;
    logic [7:0]       digit_off;
    logic             is_digit;

    // byte load at end of start or ack slot
    logic             do_load;
    logic [LEN_W-1:0] load_ptr;
    logic [LEN_W-1:0] ptr_next;

    logic             flag_done;
    logic             flag_err;
    logic             flag_ovf;
    t_result          result;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = can_push;
    assign op         = t_op'(i_in.operation);
    assign digit_off  = i_in.value - CHAR_ZERO;
    assign is_digit   = (i_in.value >= CHAR_ZERO) && (i_in.value <= CHAR_NINE);
    assign ptr_next   = r_byte_ptr + LEN_W'(1);
    assign rd_byte    = r_byp_valid ? r_byp_data : ram_rd_data;

    ssw_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // next state, buffer writes and per-transaction flags
    always_comb begin
        n_phase     = r_phase;
        n_half      = r_half;
        n_bit_cnt   = r_bit_cnt;
        n_byte_ptr  = r_byte_ptr;
        n_shift     = r_shift;
        n_nack      = r_nack;
        n_frame_len = r_frame_len;
        n_char_idx  = r_char_idx;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_frame_len[PTR_W-1:0];
        ram_wr_data = i_in.value;
        do_load     = 1'b0;
        load_ptr    = r_byte_ptr;
        flag_done   = 1'b0;
        flag_err    = 1'b0;
        flag_ovf    = 1'b0;

        if (accept) begin
            case (op)
                OP_TICK: begin
                    case (r_phase)
                        PH_START: begin
                            if (!r_half) begin
                                n_half = 1'b1;
                            end else begin
                                do_load = 1'b1;
                            end
                        end
                        PH_BITS: begin
                            if (!r_half) begin
                                n_half = 1'b1;
                            end else if (r_bit_cnt == 3'd7) begin
                                n_phase = PH_ACK;
                                n_half  = 1'b0;
                            end else begin
                                n_bit_cnt = r_bit_cnt + 3'd1;
                                n_half    = 1'b0;
                            end
                        end
                        PH_ACK: begin
                            // ack sampled as the clock rises
                            if (!r_half) begin
                                if (i_in.dio_in) begin
                                    n_nack = 1'b1;
                                end
                                n_half = 1'b1;
                            end else begin
                                n_byte_ptr = ptr_next;
                                load_ptr   = ptr_next;
                                do_load    = 1'b1;
                            end
                        end
                        PH_STOP: begin
                            if (!r_half) begin
                                n_half = 1'b1;
                            end else begin
                                // frame consumed
                                n_phase     = PH_IDLE;
                                n_half      = 1'b0;
                                n_frame_len = '0;
                                n_char_idx  = '0;
                                n_byte_ptr  = '0;
                                flag_done   = 1'b1;
                                flag_err    = r_nack;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_RAW: begin
                    if (r_phase != PH_IDLE || r_frame_len >= LEN_W'(FRAME_BYTES)) begin
                        flag_ovf = 1'b1;
                    end else begin
                        ram_wr_en   = 1'b1;
                        n_frame_len = r_frame_len + LEN_W'(1);
                    end
                end
                OP_CHAR: begin
                    if (r_phase != PH_IDLE || r_char_idx >= MAX_CHARS) begin
                        flag_ovf = 1'b1;
                    end else if (i_in.value == CHAR_COLON && r_char_idx == COLON_INDEX
                                 && !is_digit) begin
                        // colon lights the point of the previous digit
                        if (r_frame_len != '0) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = PTR_W'(r_frame_len - LEN_W'(1));
                            ram_wr_data = rd_byte | SEG_POINT;
                        end
                        n_char_idx = r_char_idx + 3'd1;
                    end else if (r_frame_len >= LEN_W'(FRAME_BYTES)) begin
                        flag_ovf = 1'b1;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = is_digit ? seg_code(digit_off[3:0]) : 8'h00;
                        n_frame_len = r_frame_len + LEN_W'(1);
                        n_char_idx  = r_char_idx + 3'd1;
                    end
                end
                OP_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_phase    = PH_START;
                        n_half     = 1'b0;
                        n_bit_cnt  = '0;
                        n_byte_ptr = '0;
                        n_nack     = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        // next byte of the frame or the stop condition
        if (do_load) begin
            n_half = 1'b0;
            if (load_ptr < r_frame_len && load_ptr < LEN_W'(FRAME_BYTES)) begin
                n_shift   = rd_byte;
                n_bit_cnt = '0;
                n_phase   = PH_BITS;
            end else begin
                n_phase = PH_STOP;
            end
        end
    end

    // read address for the coming cycle: last stored byte while idle,
    // otherwise the byte the next load will want
    always_comb begin
        case (n_phase)
            PH_IDLE:  ram_rd_addr = PTR_W'(n_frame_len - LEN_W'(1));
            PH_START: ram_rd_addr = n_byte_ptr[PTR_W-1:0];
            default:  ram_rd_addr = PTR_W'(n_byte_ptr + LEN_W'(1));
        endcase
        n_byp_valid = ram_wr_en && (ram_wr_addr == ram_rd_addr);
    end

    // line levels of the half period after this transaction
    always_comb begin
        result             = '0;
        result.clk_level   = 1'b1;
        result.dio_level   = 1'b1;
        result.dio_release = 1'b0;
        case (n_phase)
            PH_START: begin
                result.dio_level = !n_half;
            end
            PH_BITS: begin
                result.clk_level = n_half;
                result.dio_level = n_shift[n_bit_cnt];
            end
            PH_ACK: begin
                result.clk_level   = n_half;
                result.dio_level   = 1'b0;
                result.dio_release = 1'b1;
            end
            PH_STOP: begin
                result.clk_level = n_half;
                result.dio_level = 1'b0;
            end
            default: begin
            end
        endcase
        result.busy_res   = (n_phase != PH_IDLE);
        result.frame_done = flag_done;
        result.ack_error  = flag_err;
        result.overflow   = flag_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_half      <= 1'b0;
            r_bit_cnt   <= '0;
            r_byte_ptr  <= '0;
            r_nack      <= 1'b0;
            r_frame_len <= '0;
            r_char_idx  <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_half      <= n_half;
            r_bit_cnt   <= n_bit_cnt;
            r_byte_ptr  <= n_byte_ptr;
            r_nack      <= n_nack;
            r_frame_len <= n_frame_len;
            r_char_idx  <= n_char_idx;
            r_byp_valid <= n_byp_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_byp_data <= ram_wr_data;
    end

    ssw_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_result   (result),
        .o_can_push (can_push),
        .o_out      (o_out)
    );

    // buffer never written while a frame is on the bus
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (r_phase == PH_IDLE))
        else $error("frame buffer written while busy");

    // frame length bounded by the buffer depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_len <= LEN_W'(FRAME_BYTES))
        else $error("frame length beyond buffer");

    // idle bus always has the byte pointer rewound
    a_idle_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_byte_ptr == '0))
        else $error("byte pointer not rewound when idle");

    // bypass only follows a write
    a_byp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_valid |-> $past(ram_wr_en))
        else $error("bypass without write");

    // character count never passes the display width
    a_char_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_idx <= MAX_CHARS)
        else $error("character index out of range");

endmodule

`default_nettype wire

/* bench/tb_seven_segment_two_wire_writer.sv */
`timescale 1ns / 1ps
// testbench for the two-wire display writer: directed frames, then random frames
// depends on ssw_pkg, ssw_if and seven_segment_two_wire_writer
module tb_seven_segment_two_wire_writer
    import ssw_pkg::*;
();

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 8;
    localparam int MAX_WAIT        = 19;
    // long receiver hold-off, well past the two result registers of the block
    localparam int HOLD_OFF_CYCLES = 64;
    // longest legal quiet stretch is the hold-off plus a sender gap, so this is ample
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int ITEM_TARGET     = 1950;
    localparam int MAX_REPORTS     = 100;

    logic i_clk;
    logic i_rst_n;

    ssw_in_if  in_ch ();
    ssw_out_if out_ch ();

    seven_segment_two_wire_writer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // bench copy of the bus master state
    logic [7:0]       frame_buf [FRAME_BYTES];
    logic [LEN_W-1:0] buf_len;
    logic [2:0]       chars_taken;
    t_phase           bus_phase;
    logic             second_half;
    logic [2:0]       bit_idx;
    logic [LEN_W-1:0] byte_idx;
    logic [7:0]       out_byte;
    logic             nack_flag;

    logic [7:0] digit_segments [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                        8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};
    string      field_names [7] = '{"clk_level", "dio_level", "dio_release", "busy_res",
                                    "frame_done", "ack_error", "overflow"};

    // line levels still owed by the block, oldest first
    t_result pending_levels [$];

    int  mismatch_count;
    int  sent_items;
    int  ignored_items;
    int  quiet_cycles;
    bit  source_burst;
    bit  sink_burst;
    bit  hold_off_request;

    // ------------------------------------------------------------------
    // bus model
    // ------------------------------------------------------------------

    function automatic void clear_bus_model();
        foreach (frame_buf[k]) frame_buf[k] = 8'h00;
        buf_len     = '0;
        chars_taken = '0;
        bus_phase   = PH_IDLE;
        second_half = 1'b0;
        bit_idx     = '0;
        byte_idx    = '0;
        out_byte    = '0;
        nack_flag   = 1'b0;
    endfunction

    // next byte of the frame, or the stop condition once the frame is used up
    function automatic void load_next_byte();
        if (byte_idx < buf_len && byte_idx < FRAME_BYTES) begin
            out_byte  = frame_buf[byte_idx[PTR_W-1:0]];
            bit_idx   = '0;
            bus_phase = PH_BITS;
        end else begin
            bus_phase = PH_STOP;
        end
        second_half = 1'b0;
    endfunction

    function automatic logic store_byte(input logic [7:0] b);
        if (buf_len >= FRAME_BYTES) return 1'b0;
        frame_buf[buf_len[PTR_W-1:0]] = b;
        buf_len = buf_len + LEN_W'(1);
        return 1'b1;
    endfunction

    // one transaction through the model: updates its state, gives the line levels
    function automatic t_result bus_step(input t_op op, input logic [7:0] val,
                                         input logic dio);
        t_result r;
        r = '0;
        case (op)
            OP_TICK: begin
                case (bus_phase)
                    PH_START: begin
                        if (!second_half) second_half = 1'b1;
                        else load_next_byte();
                    end
                    PH_BITS: begin
                        if (!second_half) begin
                            second_half = 1'b1;
                        end else if (bit_idx == 3'd7) begin
                            bus_phase   = PH_ACK;
                            second_half = 1'b0;
                        end else begin
                            bit_idx     = bit_idx + 3'd1;
                            second_half = 1'b0;
                        end
                    end
                    PH_ACK: begin
                        // data line sampled as the clock rises in the ack slot
                        if (!second_half) begin
                            if (dio) nack_flag = 1'b1;
                            second_half = 1'b1;
                        end else begin
                            byte_idx = byte_idx + LEN_W'(1);
                            load_next_byte();
                        end
                    end
                    PH_STOP: begin
                        if (!second_half) begin
                            second_half = 1'b1;
                        end else begin
                            bus_phase     = PH_IDLE;
                            second_half   = 1'b0;
                            buf_len       = '0;
                            chars_taken   = '0;
                            byte_idx      = '0;
                            r.frame_done  = 1'b1;
                            r.ack_error   = nack_flag;
                        end
                    end
                    default: ;
                endcase
            end
            OP_RAW: begin
                if (bus_phase != PH_IDLE) r.overflow = 1'b1;
                else if (!store_byte(val)) r.overflow = 1'b1;
            end
            OP_CHAR: begin
                if (bus_phase != PH_IDLE || chars_taken >= MAX_CHARS) begin
                    r.overflow = 1'b1;
                end else if (val >= CHAR_ZERO && val <= CHAR_NINE) begin
                    if (store_byte(digit_segments[val - CHAR_ZERO])) chars_taken++;
                    else r.overflow = 1'b1;
                end else if (val == CHAR_COLON && chars_taken == COLON_INDEX) begin
                    // colon lights the point of the previous digit
                    if (buf_len > 0)
                        frame_buf[buf_len[PTR_W-1:0] - 1'b1] |= SEG_POINT;
                    chars_taken++;
                end else begin
                    if (store_byte(8'h00)) chars_taken++;
                    else r.overflow = 1'b1;
                end
            end
            OP_START: begin
                if (bus_phase == PH_IDLE) begin
                    bus_phase   = PH_START;
                    second_half = 1'b0;
                    bit_idx     = '0;
                    byte_idx    = '0;
                    nack_flag   = 1'b0;
                end
            end
            default: ;
        endcase

        r.clk_level   = 1'b1;
        r.dio_level   = 1'b1;
        r.dio_release = 1'b0;
        case (bus_phase)
            PH_START: r.dio_level = ~second_half;
            PH_BITS: begin
                r.clk_level = second_half;
                r.dio_level = out_byte[bit_idx];
            end
            PH_ACK: begin
                r.clk_level   = second_half;
                r.dio_level   = 1'b0;
                r.dio_release = 1'b1;
            end
            PH_STOP: begin
                r.clk_level = second_half;
                r.dio_level = 1'b0;
            end
            default: ;
        endcase
        r.busy_res = (bus_phase != PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, reporting, sender and receiver
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // printing is capped so a badly broken block cannot flood the log
    task automatic report_failure(input string msg);
        if (mismatch_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // offers one transaction after a random gap and waits for it to be taken
    task automatic send_item(input t_op op, input logic [7:0] val, input logic dio);
        int gap;
        gap = source_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.value     <= val;
        in_ch.dio_in    <= dio;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_levels.push_back(bus_step(op, val, dio));
        sent_items++;
    endtask

    // receiver: random stall per result, or the long hold-off when asked for one
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // compare each accepted result with the oldest outstanding prediction
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.clk_level, out_ch.dio_level, out_ch.dio_release, out_ch.busy_res,
                   out_ch.frame_done, out_ch.ack_error, out_ch.overflow};
            if (pending_levels.size() == 0) begin
                report_failure("result with no transaction outstanding");
            end else begin
                want = pending_levels.pop_front();
                for (int b = 6; b >= 0; b--)
                    if (got[b] !== want[b])
                        report_failure($sformatf("%s got %b expected %b",
                                                 field_names[6-b], got[b], want[b]));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // ticks the frame to its end; nack_pct sets how often an ack slot reads high,
    // noise_pct how often a request the busy block must ignore is slipped in
    task automatic finish_frame(input int nack_pct, input int noise_pct);
        while (bus_phase != PH_IDLE) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_item(t_op'($urandom_range(OP_RAW, OP_START)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                ignored_items++;
            end else begin
                send_item(OP_TICK, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 99) < nack_pct));
            end
        end
    endtask

    // raw byte or display character; characters lean towards digits and the colon
    task automatic append_random();
        logic [7:0] ch;
        int         pick;
        if ($urandom_range(0, 1) == 0) begin
            send_item(OP_RAW, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 10)      ch = CHAR_ZERO + 8'($urandom_range(0, 9));
            else if (pick < 13) ch = CHAR_COLON;
            else                ch = 8'($urandom_range(0, 255));
            send_item(OP_CHAR, ch, 1'($urandom_range(0, 1)));
        end
    endtask

    // tick while idle, a frame with no bytes, and a start while already busy
    task automatic test_empty_frame();
        send_item(OP_TICK, 8'h00, 1'b1);
        send_item(OP_START, 8'hff, 1'b0);
        send_item(OP_START, 8'h00, 1'b1);
        finish_frame(0, 0);
        send_item(OP_TICK, 8'hff, 1'b0);
    endtask

    // digit codes, colon at index 2 and elsewhere, a non-digit, the sixth character
    // and a full buffer, then the whole eight-byte frame with mixed acks
    task automatic test_display_characters();
        send_item(OP_CHAR, CHAR_ZERO, 1'b0);
        send_item(OP_CHAR, CHAR_NINE, 1'b1);
        send_item(OP_CHAR, CHAR_COLON, 1'b0);
        send_item(OP_CHAR, CHAR_ZERO - 8'd1, 1'b0);
        send_item(OP_CHAR, CHAR_COLON, 1'b1);
        send_item(OP_CHAR, CHAR_ZERO + 8'd5, 1'b0);
        send_item(OP_RAW, 8'hff, 1'b0);
        send_item(OP_RAW, 8'h00, 1'b1);
        send_item(OP_RAW, 8'ha5, 1'b0);
        send_item(OP_RAW, 8'h5a, 1'b1);
        send_item(OP_RAW, 8'h12, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        finish_frame(50, 0);
    endtask

    // appends and start while busy are refused; every ack reads high
    task automatic test_busy_requests_and_nack();
        send_item(OP_RAW, 8'h81, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_RAW, 8'h7e, 1'b0);
        send_item(OP_CHAR, CHAR_ZERO + 8'd3, 1'b1);
        send_item(OP_START, 8'hff, 1'b1);
        finish_frame(100, 0);
    endtask

    // random frames: mostly well formed, some left unsent so appends pile up and
    // overflow, noise while busy; every tenth frame starts with the long hold-off
    task automatic test_random_frames();
        int frame_no;
        int pick;
        int n_appends;
        int nack_pct;
        frame_no = 0;
        while (sent_items - ignored_items < ITEM_TARGET) begin
            source_burst = ($urandom_range(0, 2) == 0);
            sink_burst   = ($urandom_range(0, 2) == 0);
            if (frame_no % 10 == 3) begin
                source_burst     = 1'b1;
                hold_off_request = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7)      n_appends = $urandom_range(0, 3);
            else if (pick < 9) n_appends = $urandom_range(4, 7);
            else               n_appends = $urandom_range(8, 12);
            pick = $urandom_range(0, 3);
            nack_pct = (pick == 0) ? 50 : (pick == 1) ? 5 : 0;
            repeat (n_appends) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    ignored_items++;
                end
                append_random();
            end
            if ($urandom_range(0, 19) != 0) begin
                send_item(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                finish_frame(nack_pct, 8);
            end
            frame_no++;
        end
        source_burst = 1'b0;
        sink_burst   = 1'b0;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= OP_TICK;
        in_ch.value      <= 8'h00;
        in_ch.dio_in     <= 1'b0;
        mismatch_count   = 0;
        sent_items       = 0;
        ignored_items    = 0;
        source_burst     = 1'b0;
        sink_burst       = 1'b0;
        hold_off_request = 1'b0;
        clear_bus_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_frame();
        test_display_characters();
        test_busy_requests_and_nack();
        test_random_frames();

        in_ch.valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        // catch any stray result after the last one owed
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/ssw_pkg.sv
design/ssw_if.sv
design/ssw_ram.sv
design/ssw_out_stage.sv
design/seven_segment_two_wire_writer.sv
bench/tb_seven_segment_two_wire_writer.sv
